// ----- sv/rpc_pkg.sv -----
// Shared types and constants of the point rotate/project/clip pipeline.
`default_nettype none
package rpc_pkg;

  // field widths
  localparam int CW     = 32;           // model coordinates and camera registers, Q16.16
  localparam int AW     = 16;           // binary angle
  localparam int LW     = 16;           // lens factor
  localparam int KIND_W = 4;
  localparam int ANGLE_BITS = 16;
  localparam logic [AW-1:0] ANGLE_MASK = ~((AW'(1) << (AW - ANGLE_BITS)) - AW'(1));

  // screen
  localparam int HALF_WIDTH  = 160;
  localparam int HALF_HEIGHT = 100;
  localparam int HALF_MAX    = (HALF_WIDTH > HALF_HEIGHT) ? HALF_WIDTH : HALF_HEIGHT;
  localparam int XW          = $clog2(2 * HALF_WIDTH);
  localparam int YW          = $clog2(2 * HALF_HEIGHT);

  // quarter-wave sine
  localparam int SIN_TW = AW - 1;       // phase within quadrant, 0..2^(AW-2) inclusive
  localparam int SIN_W  = 15;           // sine magnitude, Q0.15
  localparam int TRIG_W = SIN_W + 1;    // signed sine/cosine
  localparam logic [SIN_TW-1:0] QUARTER = SIN_TW'(1) << (AW - 2);
  localparam logic [10:0] SIN_K1  = 11'd1160;
  localparam logic [13:0] SIN_K2  = 14'd10512;
  localparam logic [14:0] SIN_K3  = 15'd25736;
  localparam logic [16:0] SIN_SAT = 17'd32767;

  // datapath widths
  localparam int RW   = CW + 4;         // rotated coordinate
  localparam int TW   = RW + 1;         // camera-space coordinate
  localparam int DW   = RW + 2;         // depth terms and divisor
  localparam int NW   = TW + LW;        // lens product magnitude
  localparam int QW   = $clog2(HALF_MAX); // quotient bits
  localparam int REMW = DW + QW;        // divider partial remainder

  localparam logic signed [DW-1:0] NEAR_LIMIT = -(DW'(5) <<< 16);
  localparam logic signed [DW-1:0] LENS_DEPTH = DW'(256) <<< 16;

  // output queue
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_CAM_X   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CAM_Y   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CAM_Z   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ANGLE_X = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ANGLE_Y = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_ANGLE_Z = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_LENS    = 3'd6;

  typedef enum logic [1:0] {
    ST_DRAWN = 2'd0,
    ST_NEAR  = 2'd1,
    ST_OFF   = 2'd2,
    ST_NOPT  = 2'd3
  } status_t;

  typedef struct packed {
    logic kind_nz;
    logic last;
  } side_t;

  typedef struct packed {
    logic [REMW-1:0] rem_x;
    logic [REMW-1:0] rem_y;
    logic [REMW-1:0] dsh;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
    status_t         status;
    logic            neg_x;
    logic            neg_y;
    logic            last;
  } div_t;

  typedef struct packed {
    status_t       status;
    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic          last;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/point_rotate_project_clip_top.sv -----
// Top level: rotate a point by three camera angles, move to camera space, project and clip.
// Throughput: one point per cycle while the credit count is below the queue depth; the pipeline
// never stalls, a 32-entry result queue with a credit count holds results while the output side waits.
// Angle registers feed a free-running sine pipeline.
// Reset (rst_n, synchronous) restores register defaults and empties pipeline and queue.
`default_nettype none
module point_rotate_project_clip_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [3*rpc_pkg::CW-1:0]    in_tdata,   // px, py, pz
  input  logic [rpc_pkg::KIND_W-1:0]  in_tuser,   // point_kind
  input  logic                        in_tlast,   // last_point
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // screen_x, screen_y, zero pad
  output logic [1:0]                  out_tuser,  // status
  output logic                        out_tlast,  // frame_end
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rpc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rpc_pkg::CW-1:0]      cfg_data
);
  import rpc_pkg::*;

  localparam int DLY_N  = 5;   // capture plus alignment to the sine pipeline
  localparam int OUT_PAD = 24 - XW - YW;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    side_t                side;
  } pt_in_t;

  // ---------------- configuration registers ----------------
  logic signed [CW-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [AW-1:0]        angle_x_r, angle_y_r, angle_z_r;
  logic [LW-1:0]        lens_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= CW'(32'h0100_0000);
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
      lens_r    <= LW'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAM_X:   cam_x_r   <= cfg_data;
        CFG_CAM_Y:   cam_y_r   <= cfg_data;
        CFG_CAM_Z:   cam_z_r   <= cfg_data;
        CFG_ANGLE_X: angle_x_r <= cfg_data[AW-1:0];
        CFG_ANGLE_Y: angle_y_r <= cfg_data[AW-1:0];
        CFG_ANGLE_Z: angle_z_r <= cfg_data[AW-1:0];
        CFG_LENS:    lens_r    <= cfg_data[LW-1:0];
        default: ;   // unknown index: write dropped
      endcase
    end
  end

  // ---------------- sine / cosine per axis ----------------
  // S(t) and S(quarter - t) per axis; quadrant picks magnitude and sign.
  logic [AW-1:0]            ang_q [3];
  logic signed [TRIG_W-1:0] sin_r [3];
  logic signed [TRIG_W-1:0] cos_r [3];

  assign ang_q[0] = angle_x_r & ANGLE_MASK;
  assign ang_q[1] = angle_y_r & ANGLE_MASK;
  assign ang_q[2] = angle_z_r & ANGLE_MASK;

  for (genvar a = 0; a < 3; a++) begin : g_trig
    logic [SIN_TW-1:0] ta, tb;
    logic [SIN_W-1:0]  sa, sb, mag_s, mag_c;
    logic [1:0]        q;

    assign q  = ang_q[a][AW-1:AW-2];
    assign ta = {1'b0, ang_q[a][AW-3:0]};
    assign tb = QUARTER - ta;

    rpc_sine u_sin_a (.clk(clk), .t(ta), .s_r(sa));
    rpc_sine u_sin_b (.clk(clk), .t(tb), .s_r(sb));

    assign mag_s = q[0] ? sb : sa;
    assign mag_c = q[0] ? sa : sb;

    always_ff @(posedge clk) begin
      sin_r[a] <= q[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
      cos_r[a] <= (q[1] ^ q[0]) ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

  // ---------------- input capture and alignment ----------------
  logic             in_fire, out_fire;
  pt_in_t           in_pt;
  pt_in_t           dly_r [DLY_N];
  logic [DLY_N-1:0] dly_v_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  assign in_pt.px           = in_tdata[0*CW +: CW];
  assign in_pt.py           = in_tdata[1*CW +: CW];
  assign in_pt.pz           = in_tdata[2*CW +: CW];
  assign in_pt.side.kind_nz = |in_tuser;
  assign in_pt.side.last    = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_v_r <= '0;
    end else begin
      dly_v_r <= {dly_v_r[DLY_N-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= in_pt;
    for (int i = 1; i < DLY_N; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  // ---------------- rotations: about X, then Y, then Z ----------------
  logic                 rx_v, ry_v, rz_v;
  logic signed [RW-1:0] rx_u, rx_v_o, rx_w;   // y', z', x
  logic signed [RW-1:0] ry_u, ry_v_o, ry_w;   // z'', x'', y'
  logic signed [RW-1:0] rz_u, rz_v_o, rz_w;   // x''', y''', z''
  side_t                rx_side, ry_side, rz_side;

  rpc_rotate u_rot_x (
    .clk(clk), .rst_n(rst_n), .in_vld(dly_v_r[DLY_N-1]),
    .u(RW'($signed(dly_r[DLY_N-1].py))),
    .v(RW'($signed(dly_r[DLY_N-1].pz))),
    .w(RW'($signed(dly_r[DLY_N-1].px))),
    .side(dly_r[DLY_N-1].side), .sn(sin_r[0]), .cs(cos_r[0]),
    .vld_r(rx_v), .u_r(rx_u), .v_r(rx_v_o), .w_r(rx_w), .side_r(rx_side)
  );

  rpc_rotate u_rot_y (
    .clk(clk), .rst_n(rst_n), .in_vld(rx_v),
    .u(rx_v_o), .v(rx_w), .w(rx_u),
    .side(rx_side), .sn(sin_r[1]), .cs(cos_r[1]),
    .vld_r(ry_v), .u_r(ry_u), .v_r(ry_v_o), .w_r(ry_w), .side_r(ry_side)
  );

  rpc_rotate u_rot_z (
    .clk(clk), .rst_n(rst_n), .in_vld(ry_v),
    .u(ry_v_o), .v(ry_w), .w(ry_u),
    .side(ry_side), .sn(sin_r[2]), .cs(cos_r[2]),
    .vld_r(rz_v), .u_r(rz_u), .v_r(rz_v_o), .w_r(rz_w), .side_r(rz_side)
  );

  // ---------------- camera space and depth ----------------
  // zz = zr - 2*cam_z: near unless zz < -5.0; divisor d = -zz - 256.0
  logic                 t_v_r;
  logic signed [TW-1:0] tx_r, ty_r;
  logic signed [DW-1:0] d_r;
  logic                 near_r;
  side_t                t_side_r;
  logic signed [DW-1:0] zz;

  assign zz = DW'(rz_w) - (DW'(cam_z_r) <<< 1);

  always_ff @(posedge clk) begin
    tx_r     <= TW'(rz_u) - TW'(cam_x_r);
    ty_r     <= TW'(rz_v_o) - TW'(cam_y_r);
    d_r      <= -zz - LENS_DEPTH;
    near_r   <= !(zz < NEAR_LIMIT);
    t_side_r <= rz_side;
  end

  // ---------------- lens products as magnitudes ----------------
  // signs are folded into neg_x / neg_y relative to the divisor sign
  logic          m_v_r;
  logic [NW-1:0] ax_r, ay_r;
  logic [DW-1:0] ad_r;
  logic          neg_x_r, neg_y_r, dz_r, m_near_r;
  side_t         m_side_r;
  logic [TW-1:0] abs_x, abs_y;

  assign abs_x = tx_r[TW-1] ? TW'(-tx_r) : TW'(tx_r);
  assign abs_y = ty_r[TW-1] ? TW'(-ty_r) : TW'(ty_r);

  always_ff @(posedge clk) begin
    ax_r     <= NW'(lens_r) * NW'(abs_x);
    ay_r     <= NW'(lens_r) * NW'(abs_y);
    ad_r     <= d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
    dz_r     <= d_r == '0;
    neg_x_r  <= tx_r[TW-1] ^ d_r[DW-1];
    neg_y_r  <= ty_r[TW-1] ^ d_r[DW-1];
    m_near_r <= near_r;
    m_side_r <= t_side_r;
  end

  // ---------------- clip and divider load ----------------
  logic          dv_v_r;
  div_t          dv_r;
  logic [NW-1:0] lim_x, lim_y;
  status_t       st;

  always_comb begin
    lim_x = NW'(ad_r) * NW'(HALF_WIDTH);
    lim_y = NW'(ad_r) * NW'(HALF_HEIGHT);
    if (m_near_r) begin
      st = ST_NEAR;
    end else if (m_side_r.kind_nz) begin
      st = ST_NOPT;
    end else if (dz_r || !(ax_r < lim_x) || !(ay_r < lim_y)) begin
      st = ST_OFF;
    end else begin
      st = ST_DRAWN;
    end
  end

  always_ff @(posedge clk) begin
    dv_r.rem_x  <= (st == ST_DRAWN) ? REMW'(ax_r) : '0;
    dv_r.rem_y  <= (st == ST_DRAWN) ? REMW'(ay_r) : '0;
    dv_r.dsh    <= REMW'(ad_r) << (QW - 1);
    dv_r.qx     <= '0;
    dv_r.qy     <= '0;
    dv_r.status <= st;
    dv_r.neg_x  <= neg_x_r;
    dv_r.neg_y  <= neg_y_r;
    dv_r.last   <= m_side_r.last;
  end

  // valid bits of the stages above
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r  <= 1'b0;
      m_v_r  <= 1'b0;
      dv_v_r <= 1'b0;
    end else begin
      t_v_r  <= rz_v;
      m_v_r  <= t_v_r;
      dv_v_r <= m_v_r;
    end
  end

  // ---------------- divider chain: one quotient bit per cell ----------------
  div_t cd [QW+1];
  logic cv [QW+1];

  assign cd[0] = dv_r;
  assign cv[0] = dv_v_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rpc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_vld(cv[k]), .d_in(cd[k]),
      .vld_r(cv[k+1]), .d_r(cd[k+1])
    );
  end

  // ---------------- pixel and result queue ----------------
  // column = floor(sx) + HALF_WIDTH, row = HALF_HEIGHT - ceil(sy)
  div_t fd;
  logic rx_nz, ry_nz;
  res_t res, head;

  always_comb begin
    fd         = cd[QW];
    rx_nz      = |fd.rem_x;
    ry_nz      = |fd.rem_y;
    res.status = fd.status;
    res.last   = fd.last;
    res.sx     = '0;
    res.sy     = '0;
    if (fd.status == ST_DRAWN) begin
      res.sx = fd.neg_x ? XW'(HALF_WIDTH) - XW'(fd.qx) - XW'(rx_nz)
                        : XW'(HALF_WIDTH) + XW'(fd.qx);
      res.sy = fd.neg_y ? YW'(HALF_HEIGHT) + YW'(fd.qy)
                        : YW'(HALF_HEIGHT) - YW'(fd.qy) - YW'(ry_nz);
    end
  end

  rpc_out_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(cv[QW]), .push_data(res),
    .pop(out_tready), .vld(out_tvalid), .head(head)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, head.sy, head.sx};
  assign out_tuser = head.status;
  assign out_tlast = head.last;

  // credit count: points in flight plus results queued never pass the queue depth
  logic [FIFO_AW:0] occ_r;

  assign in_tready = occ_r < (FIFO_AW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + (FIFO_AW+1)'(in_fire) - (FIFO_AW+1)'(out_fire);
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_occ_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !in_fire) |=> occ_r == $past(occ_r) - 1'b1)
    else $error("credit not returned on output transfer");

  a_drawn_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_DRAWN) |->
      (head.sx < XW'(2*HALF_WIDTH)) && (head.sy < YW'(2*HALF_HEIGHT)))
    else $error("drawn pixel outside screen");

  a_blank_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_DRAWN) |-> (head.sx == '0) && (head.sy == '0))
    else $error("pixel set on a point not drawn");
`endif

endmodule
`default_nettype wire

// ----- sv/rpc_sine.sv -----
// Four-stage quarter-wave sine polynomial, Q0.15 magnitude.
`default_nettype none
module rpc_sine (
  input  logic                        clk,
  input  logic [rpc_pkg::SIN_TW-1:0]  t,
  output logic [rpc_pkg::SIN_W-1:0]   s_r
);
  import rpc_pkg::*;

  logic [SIN_TW-1:0]   t1_r, t2_r, t3_r;
  logic [SIN_TW-1:0]   z2_1_r, z2_2_r;
  logic [13:0]         inner_r;
  logic [14:0]         poly_r;
  logic [2*SIN_TW-1:0] sq;
  logic [25:0]         m1;
  logic [28:0]         m2;
  logic [2*SIN_TW-1:0] m3;
  logic [16:0]         y;
  logic [SIN_TW-1:0]   z2_nxt;
  logic [13:0]         inner_nxt;
  logic [14:0]         poly_nxt;
  logic [SIN_W-1:0]    s_nxt;

  always_comb begin
    sq        = (2*SIN_TW)'(t) * (2*SIN_TW)'(t);
    z2_nxt    = SIN_TW'(sq >> 14);
    m1        = 26'(SIN_K1) * 26'(z2_1_r);
    inner_nxt = SIN_K2 - 14'(m1 >> 14);
    m2        = 29'(z2_2_r) * 29'(inner_r);
    poly_nxt  = SIN_K3 - 15'(m2 >> 14);
    m3        = (2*SIN_TW)'(t3_r) * (2*SIN_TW)'(poly_r);
    y         = 17'(m3 >> 13);
    s_nxt     = (y > SIN_SAT) ? SIN_W'(SIN_SAT) : y[SIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    t1_r    <= t;
    z2_1_r  <= z2_nxt;
    t2_r    <= t1_r;
    z2_2_r  <= z2_1_r;
    inner_r <= inner_nxt;
    t3_r    <= t2_r;
    poly_r  <= poly_nxt;
    s_r     <= s_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/rpc_rotate.sv -----
// One axis rotation cell: product stage, then sum and floor shift stage.
`default_nettype none
module rpc_rotate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic signed [rpc_pkg::RW-1:0]   u,
  input  logic signed [rpc_pkg::RW-1:0]   v,
  input  logic signed [rpc_pkg::RW-1:0]   w,
  input  rpc_pkg::side_t                  side,
  input  logic signed [rpc_pkg::TRIG_W-1:0] sn,
  input  logic signed [rpc_pkg::TRIG_W-1:0] cs,
  output logic                            vld_r,
  output logic signed [rpc_pkg::RW-1:0]   u_r,
  output logic signed [rpc_pkg::RW-1:0]   v_r,
  output logic signed [rpc_pkg::RW-1:0]   w_r,
  output rpc_pkg::side_t                  side_r
);
  import rpc_pkg::*;

  localparam int PW = RW + TRIG_W;

  logic                 vld1_r;
  logic signed [PW-1:0] p_uc_r, p_vs_r, p_vc_r, p_us_r;
  logic signed [RW-1:0] w1_r;
  side_t                side1_r;
  logic signed [PW:0]   du, dv;
  logic signed [RW-1:0] u_nxt, v_nxt;

  // u' = u*c - v*s, v' = v*c + u*s, floor of /2^15
  always_comb begin
    du    = (PW+1)'(p_uc_r) - (PW+1)'(p_vs_r);
    dv    = (PW+1)'(p_vc_r) + (PW+1)'(p_us_r);
    u_nxt = RW'(du >>> SIN_W);
    v_nxt = RW'(dv >>> SIN_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld_r  <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_uc_r  <= u * cs;
    p_vs_r  <= v * sn;
    p_vc_r  <= v * cs;
    p_us_r  <= u * sn;
    w1_r    <= w;
    side1_r <= side;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    w_r     <= w1_r;
    side_r  <= side1_r;
  end

endmodule
`default_nettype wire

// ----- sv/rpc_div_cell.sv -----
// Restoring divider cell: one quotient bit for x and for y per cycle.
`default_nettype none
module rpc_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  rpc_pkg::div_t d_in,
  output logic          vld_r,
  output rpc_pkg::div_t d_r
);
  import rpc_pkg::*;

  logic            ge_x, ge_y;
  logic [REMW-1:0] sub_x, sub_y;
  div_t            d_nxt;

  always_comb begin
    ge_x  = d_in.rem_x >= d_in.dsh;
    ge_y  = d_in.rem_y >= d_in.dsh;
    sub_x = ge_x ? d_in.rem_x - d_in.dsh : d_in.rem_x;
    sub_y = ge_y ? d_in.rem_y - d_in.dsh : d_in.rem_y;
    d_nxt       = d_in;
    d_nxt.rem_x = sub_x << 1;
    d_nxt.rem_y = sub_y << 1;
    d_nxt.qx    = {d_in.qx[QW-2:0], ge_x};
    d_nxt.qy    = {d_in.qy[QW-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/rpc_out_fifo.sv -----
// Result queue between the free-running pipeline and the output channel.
`default_nettype none
module rpc_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpc_pkg::res_t push_data,
  input  logic          pop,
  output logic          vld,
  output rpc_pkg::res_t head
);
  import rpc_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_pop;

  assign vld    = cnt_r != '0;
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for point_rotate_project_clip_top: directed and random points checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rpc_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  DRAIN_CYCLES = 40;     // pipeline is 22 deep, sine pipe 5 more
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  PHASE_POINTS = 170;

  // expected result of one point
  typedef struct {
    status_t    st;
    bit [8:0]   col;
    bit [7:0]   row;
    bit         last;
  } pixel_t;

  // Projection predictor plus the queue of pixels still owed by the block.
  class pixel_scoreboard;
    bit signed [31:0] cam_x, cam_y, cam_z;
    bit [15:0]        ang_x, ang_y, ang_z, lens;
    pixel_t           owed[$];
    int               errors;
    int               seen[4];

    function new();
      reset_regs();
    endfunction

    function void reset_regs();
      cam_x = 0; cam_y = 0; cam_z = 32'h0100_0000;
      ang_x = 0; ang_y = 0; ang_z = 0; lens = 16'd256;
    endfunction

    function void write_reg(bit [CFG_IW-1:0] idx, bit [31:0] val);
      case (idx)
        CFG_CAM_X:   cam_x = val;
        CFG_CAM_Y:   cam_y = val;
        CFG_CAM_Z:   cam_z = val;
        CFG_ANGLE_X: ang_x = val[15:0];
        CFG_ANGLE_Y: ang_y = val[15:0];
        CFG_ANGLE_Z: ang_z = val[15:0];
        CFG_LENS:    lens  = val[15:0];
        default: ;   // unused index, ignored
      endcase
    endfunction

    // polynomial quarter wave, t in 0..16384
    function longint quarter_wave(longint t);
      longint z2, inner, poly, y;
      z2 = (t * t) >>> 14;
      inner = 10512 - ((1160 * z2) >>> 14);
      poly = 25736 - ((z2 * inner) >>> 14);
      y = (t * poly) >>> 13;
      return (y > 32767) ? 32767 : y;
    endfunction

    function longint sine(bit [15:0] ph);
      longint s;
      s = ph[14] ? quarter_wave(16384 - ph[13:0]) : quarter_wave(ph[13:0]);
      return ph[15] ? -s : s;
    endfunction

    function void turn(ref longint u, ref longint v, input bit [15:0] ang);
      bit [15:0] a;
      longint s, c, nu;
      a = ang & ANGLE_MASK;
      s = sine(a);
      c = sine(a + 16'h4000);
      nu = (u * c - v * s) >>> 15;
      v = (v * c + u * s) >>> 15;
      u = nu;
    endfunction

    function longint floor_div(longint n, longint d);
      return (n >= 0) ? n / d : -((-n + d - 1) / d);
    endfunction

    function void note_point(bit signed [31:0] px, py, pz, bit [3:0] kind, bit last);
      longint x, y, z, cz, d, nx, ny;
      pixel_t p;
      x = px; y = py; z = pz; cz = cam_z;
      turn(y, z, ang_x);
      turn(z, x, ang_y);
      turn(x, y, ang_z);
      x -= longint'(cam_x); y -= longint'(cam_y); z -= cz;
      p.col = 0; p.row = 0; p.last = last;
      if (!(z < cz - (longint'(5) << 16))) begin
        p.st = ST_NEAR;
      end else if (kind != 0) begin
        p.st = ST_NOPT;
      end else begin
        d = (cz - (longint'(256) << 16)) - z;
        nx = longint'(lens) * x;
        ny = longint'(lens) * y;
        if (d == 0) begin
          p.st = ST_OFF;
        end else begin
          if (d < 0) begin
            d = -d; nx = -nx; ny = -ny;
          end
          if (nx < HALF_WIDTH * d && nx > -HALF_WIDTH * d &&
              ny < HALF_HEIGHT * d && ny > -HALF_HEIGHT * d) begin
            p.st = ST_DRAWN;
            p.col = 9'(floor_div(nx, d) + HALF_WIDTH);
            p.row = 8'(HALF_HEIGHT + floor_div(-ny, d));
          end else begin
            p.st = ST_OFF;
          end
        end
      end
      owed.push_back(p);
    endfunction

    function void report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endfunction

    function void check_pixel(status_t st, bit [8:0] col, bit [7:0] row, bit last);
      pixel_t p;
      if (owed.size() == 0) begin
        report("result with no point outstanding");
        return;
      end
      p = owed.pop_front();
      seen[p.st]++;
      if (st != p.st) report($sformatf("status %0d, expected %0d", st, p.st));
      if (col != p.col) report($sformatf("screen_x %0d, expected %0d", col, p.col));
      if (row != p.row) report($sformatf("screen_y %0d, expected %0d", row, p.row));
      if (last != p.last) report($sformatf("frame_end %0b, expected %0b", last, p.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready, in_tlast = 1'b0;
  logic [95:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid, out_tready = 1'b0, out_tlast;
  logic [23:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // transfer flags, sampled at the rising edge and read by drivers at the falling edge
  bit in_took, out_took, cfg_took;
  bit gaps_on = 1'b1;        // random idling on both sides
  int hold_request = 0;      // receiver long hold-off, in cycles
  int cycles = 0;
  int points_sent = 0;
  pixel_scoreboard sb;

  always #HALF_PERIOD clk = ~clk;

  point_rotate_project_clip_top u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // monitor: every transfer is seen here, before the block's outputs update
  always @(posedge clk) begin
    cycles++;
    in_took  = rst_n && in_tvalid && in_tready;
    out_took = rst_n && out_tvalid && out_tready;
    cfg_took = rst_n && cfg_valid && cfg_ready;
    if (in_took)
      sb.note_point(in_tdata[31:0], in_tdata[63:32], in_tdata[95:64], in_tuser, in_tlast);
    if (out_took)
      sb.check_pixel(status_t'(out_tuser), out_tdata[8:0], out_tdata[16:9], out_tlast);
    if (cfg_took)
      sb.write_reg(cfg_index, cfg_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int w;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        out_tready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      w = gaps_on ? $urandom_range(0, 3) : 0;
      if (w > 0) begin
        out_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(negedge clk); while (!out_took && hold_request == 0);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_point(bit [31:0] px, py, pz, bit [3:0] kind, bit last);
    int w;
    w = gaps_on ? $urandom_range(0, 3) : 0;
    if (w > 0) begin
      in_tvalid = 1'b0;
      repeat (w) @(negedge clk);
    end
    in_tdata = {pz, py, px};
    in_tuser = kind;
    in_tlast = last;
    in_tvalid = 1'b1;
    do @(negedge clk); while (!in_took);
    in_tvalid = 1'b0;
    points_sent++;
  endtask

  task automatic write_reg(bit [CFG_IW-1:0] idx, bit [31:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
  endtask

  // wait for every owed pixel, then for anything still in flight
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_camera(bit [31:0] cx, cy, cz, bit [15:0] ax, ay, az, lf);
    drain();
    write_reg(CFG_CAM_X, cx);
    write_reg(CFG_CAM_Y, cy);
    write_reg(CFG_CAM_Z, cz);
    write_reg(CFG_ANGLE_X, ax);
    write_reg(CFG_ANGLE_Y, ay);
    write_reg(CFG_ANGLE_Z, az);
    write_reg(CFG_LENS, lf);
    repeat (8) @(negedge clk);     // sine pipeline settles after an angle write
  endtask

  // signed Q16.16 value in +/- span (whole units), random fraction
  function automatic bit [31:0] near_coord(int span);
    return 32'($urandom_range(0, 2 * span * 65536) - span * 65536);
  endfunction

  // mostly well-formed points in front of the camera, some raw noise
  task automatic random_point(bit [31:0] cz);
    bit [31:0] x, y, z;
    bit [3:0] kind;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      x = near_coord(250);
      y = near_coord(160);
      z = 32'($signed(cz)) - 32'($urandom_range(0, 600 << 16)) + 32'(100 << 16);
    end else begin
      x = $urandom; y = $urandom; z = $urandom;
    end
    kind = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    send_point(x, y, z, kind, $urandom_range(0, 15) == 0);
  endtask

  task automatic random_phase(bit [31:0] cz, int n);
    repeat (n) random_point(cz);
  endtask

  initial begin
    bit [31:0] cz;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, reset camera: 1 px per unit around the screen center
    send_point(0, 0, 0, 0, 0);                          // screen center
    send_point(32'h009F_FFFF, 32'h0063_FFFF, 0, 0, 0);  // just inside both edges
    send_point(32'h00A0_0000, 0, 0, 0, 0);              // right edge, off
    send_point(32'hFF60_0000, 0, 0, 0, 0);              // left edge, off
    send_point(32'hFF60_0001, 32'hFF9C_0001, 0, 0, 0);  // just inside negative edges
    send_point(0, 32'h0064_0000, 0, 0, 1);              // top edge, off
    send_point(0, 32'hFF9C_0000, 0, 0, 0);              // bottom edge, off
    send_point(32'h0000_8000, 32'hFFFF_8000, 0, 0, 0);  // half-pixel rounding
    send_point(0, 0, 32'h0100_0000, 0, 0);              // zero divisor
    send_point(32'h0001_0000, 32'h0001_0000, 32'h012C_0000, 0, 0); // behind lens plane
    send_point(0, 0, 32'h01FB_0000, 0, 0);              // exactly at near limit
    send_point(0, 0, 32'h01FA_FFFF, 0, 0);              // just in front of it
    send_point(0, 0, 32'h7FFF_FFFF, 9, 0);              // too near wins over kind
    send_point(0, 0, 0, 9, 0);                          // not a point
    send_point(0, 0, 0, 15, 1);                         // widest kind code
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_point(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1);

    // extremes of every register
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000,
               16'hFFFF, 16'hFFFF);
    write_reg(3'd7, 32'hDEAD_BEEF);                     // unused index, ignored
    random_phase(32'h7FFF_FFFF, 40);
    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h4000,
               16'hC000, 16'd1);
    random_phase(32'h8000_0000, 40);
    set_camera(0, 0, 32'h0100_0000, 16'h4000, 16'h4000, 16'h4000, 16'd256);
    random_phase(32'h0100_0000, 60);

    // random cameras; long hold-off in one, no idling in another
    for (int ph = 0; ph < 9; ph++) begin
      cz = 32'($urandom_range(0, 800 << 16)) - 32'(200 << 16);
      set_camera(near_coord(60), near_coord(60), cz, 16'($urandom), 16'($urandom),
                 16'($urandom),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(32, 600)));
      gaps_on = (ph != 3);
      if (ph == 1) hold_request = 300;
      random_phase(cz, PHASE_POINTS / 2);
      if (ph == 5) while (sb.owed.size() != 0) @(negedge clk);  // sender pause
      random_phase(cz, PHASE_POINTS / 2);
    end
    gaps_on = 1'b1;

    drain();
    $display("Sent %0d points over 13 camera settings, incl. register extremes.",
             points_sent);
    $display("Results: %0d drawn, %0d too near, %0d off screen, %0d not a point.",
             sb.seen[ST_DRAWN], sb.seen[ST_NEAR], sb.seen[ST_OFF], sb.seen[ST_NOPT]);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/rpc_pkg.sv
sv/rpc_sine.sv
sv/rpc_rotate.sv
sv/rpc_div_cell.sv
sv/rpc_out_fifo.sv
sv/point_rotate_project_clip_top.sv
sim/tb_top.sv
